// File: rtl/zscii_text_word_decoder_top_assert.svh
// Assertion helpers for the ZSCII text word decoder
`ifndef ZSCII_TEXT_WORD_DECODER_TOP_ASSERT_SVH
`define ZSCII_TEXT_WORD_DECODER_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define ZSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent
`define ZSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/zsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package zsd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_ABBREV = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // Pending modes
  localparam logic [1:0] PEND_NONE   = 2'd0;
  localparam logic [1:0] PEND_ABBR   = 2'd1;
  localparam logic [1:0] PEND_LIT_HI = 2'd2;
  localparam logic [1:0] PEND_LIT_LO = 2'd3;

  // Alphabet shifts
  localparam logic [1:0] SHIFT_LOWER = 2'd0;
  localparam logic [1:0] SHIFT_UPPER = 2'd1;
  localparam logic [1:0] SHIFT_PUNCT = 2'd2;

  // Special codes
  localparam logic [4:0] CODE_SPACE   = 5'd0;
  localparam logic [4:0] CODE_ABBR_HI = 5'd3;
  localparam logic [4:0] CODE_SH_UP   = 5'd4;
  localparam logic [4:0] CODE_SH_PUN  = 5'd5;
  localparam logic [4:0] CODE_LITERAL = 5'd6;
  localparam logic [4:0] CODE_BASE    = 5'd6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_QUERY = 8'h3f;

  localparam int NUM_LANES = 3;
  localparam int NUM_RES   = NUM_LANES + 1;

  // Running decoder state between codes
  typedef struct packed {
    logic [1:0] shift;
    logic [1:0] pmode;
    logic [4:0] pbits;
  } dec_state_t;

  // One result slot as produced by a lane
  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic [7:0] ch;
    logic [6:0] idx;
  } dec_res_t;

  // Stored result entry
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [6:0] idx;
  } out_ent_t;

  // Punctuation alphabet, indexed by code minus six; the escape slot reads '?'
  function automatic logic [7:0] punct_char(input logic [4:0] i);
    logic [7:0] c;
    case (i)
      5'd1:    c = 8'h0a;
      5'd2:    c = 8'h30;
      5'd3:    c = 8'h31;
      5'd4:    c = 8'h32;
      5'd5:    c = 8'h33;
      5'd6:    c = 8'h34;
      5'd7:    c = 8'h35;
      5'd8:    c = 8'h36;
      5'd9:    c = 8'h37;
      5'd10:   c = 8'h38;
      5'd11:   c = 8'h39;
      5'd12:   c = 8'h2e;
      5'd13:   c = 8'h2c;
      5'd14:   c = 8'h21;
      5'd15:   c = 8'h3f;
      5'd16:   c = 8'h5f;
      5'd17:   c = 8'h23;
      5'd18:   c = 8'h27;
      5'd19:   c = 8'h22;
      5'd20:   c = 8'h2f;
      5'd21:   c = 8'h5c;
      5'd22:   c = 8'h2d;
      5'd23:   c = 8'h3a;
      5'd24:   c = 8'h28;
      5'd25:   c = 8'h29;
      default: c = CH_QUERY;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/zsd_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// Decodes one 5-bit code against the incoming state
module zsd_lane (
  input  wire logic                zcode,
  input  wire logic [4:0]          code,
  input  wire logic                abbrev_en,
  input  wire zsd_pkg::dec_state_t st_in,
  output zsd_pkg::dec_state_t      st_out,
  output zsd_pkg::dec_res_t        res
);

  logic [4:0] rel;

  assign rel = code - zsd_pkg::CODE_BASE;

  always_comb begin
    st_out = st_in;
    res    = '0;
    unique case (st_in.pmode)
      // abbreviation code completes the request
      zsd_pkg::PEND_ABBR: begin
        res.vld      = zcode;
        res.kind     = zsd_pkg::KIND_ABBREV;
        res.idx      = {st_in.pbits[1:0] - 2'd1, code};
        st_out.pmode = zsd_pkg::PEND_NONE;
        st_out.pbits = '0;
      end
      // literal high half
      zsd_pkg::PEND_LIT_HI: begin
        st_out.pbits = code;
        st_out.pmode = zsd_pkg::PEND_LIT_LO;
      end
      // literal low half, keep low 8 bits
      zsd_pkg::PEND_LIT_LO: begin
        res.vld      = zcode;
        res.kind     = zsd_pkg::KIND_CHAR;
        res.ch       = {st_in.pbits[2:0], code};
        st_out.pmode = zsd_pkg::PEND_NONE;
        st_out.pbits = '0;
      end
      default: begin
        if (code == zsd_pkg::CODE_SPACE) begin
          res.vld      = zcode;
          res.kind     = zsd_pkg::KIND_CHAR;
          res.ch       = zsd_pkg::CH_SPACE;
          st_out.shift = zsd_pkg::SHIFT_LOWER;
        end else if (code <= zsd_pkg::CODE_ABBR_HI) begin
          if (abbrev_en) begin
            st_out.pmode = zsd_pkg::PEND_ABBR;
            st_out.pbits = code;
          end
          st_out.shift = zsd_pkg::SHIFT_LOWER;
        end else if (code == zsd_pkg::CODE_SH_UP) begin
          st_out.shift = zsd_pkg::SHIFT_UPPER;
        end else if (code == zsd_pkg::CODE_SH_PUN) begin
          st_out.shift = zsd_pkg::SHIFT_PUNCT;
        end else if (st_in.shift == zsd_pkg::SHIFT_PUNCT &&
                     code == zsd_pkg::CODE_LITERAL) begin
          st_out.pmode = zsd_pkg::PEND_LIT_HI;
          st_out.pbits = '0;
          st_out.shift = zsd_pkg::SHIFT_LOWER;
        end else begin
          res.vld  = zcode;
          res.kind = zsd_pkg::KIND_CHAR;
          if (st_in.shift == zsd_pkg::SHIFT_LOWER) begin
            res.ch = zsd_pkg::CH_LOW_A + {3'b000, rel};
          end else if (st_in.shift == zsd_pkg::SHIFT_UPPER) begin
            res.ch = zsd_pkg::CH_UP_A + {3'b000, rel};
          end else begin
            res.ch = zsd_pkg::punct_char(rel);
          end
          st_out.shift = zsd_pkg::SHIFT_LOWER;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/zsd_merge.sv
`timescale 1ns / 1ps
`default_nettype none

// Compacts the lane results of one word and serialises them onto the output
module zsd_merge (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire zsd_pkg::dec_res_t res [zsd_pkg::NUM_RES],
  input  wire logic              accept,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output zsd_pkg::out_ent_t      out_ent,
  output logic                   out_last
);

  zsd_pkg::out_ent_t pack_slot [zsd_pkg::NUM_RES];
  logic [2:0]        pack_cnt;

  zsd_pkg::out_ent_t a_slot_r [zsd_pkg::NUM_RES];
  logic [2:0]        a_cnt_r, a_cnt_nxt;
  zsd_pkg::out_ent_t b_slot_r [zsd_pkg::NUM_RES];
  logic [2:0]        b_cnt_r, b_cnt_nxt;
  logic [1:0]        b_ptr_r, b_ptr_nxt;

  logic b_empty, b_fire, b_done, a_take;

  // Pack the valid lane results to the front, in order
  always_comb begin
    pack_cnt = '0;
    for (int i = 0; i < zsd_pkg::NUM_RES; i++) begin
      pack_slot[i] = '0;
    end
    for (int i = 0; i < zsd_pkg::NUM_RES; i++) begin
      if (res[i].vld) begin
        pack_slot[pack_cnt[1:0]] = '{kind: res[i].kind, ch: res[i].ch, idx: res[i].idx};
        pack_cnt = pack_cnt + 3'd1;
      end
    end
  end

  // Handshake between the holding stage and the emitting stage
  assign b_empty  = (b_cnt_r == 3'd0);
  assign b_fire   = !b_empty && out_ready;
  assign b_done   = b_fire && ({1'b0, b_ptr_r} == b_cnt_r - 3'd1);
  assign a_take   = (a_cnt_r != 3'd0) && (b_empty || b_done);
  assign in_ready = (a_cnt_r == 3'd0) || a_take;

  always_comb begin
    a_cnt_nxt = a_cnt_r;
    if (accept) begin
      a_cnt_nxt = pack_cnt;
    end else if (a_take) begin
      a_cnt_nxt = '0;
    end
  end

  always_comb begin
    b_cnt_nxt = b_cnt_r;
    b_ptr_nxt = b_ptr_r;
    if (b_empty || b_done) begin
      b_cnt_nxt = a_take ? a_cnt_r : 3'd0;
      b_ptr_nxt = '0;
    end else if (b_fire) begin
      b_ptr_nxt = b_ptr_r + 2'd1;
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r <= '0;
      b_cnt_r <= '0;
      b_ptr_r <= '0;
    end else begin
      a_cnt_r <= a_cnt_nxt;
      b_cnt_r <= b_cnt_nxt;
      b_ptr_r <= b_ptr_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (accept) begin
      a_slot_r <= pack_slot;
    end
    if (a_take) begin
      b_slot_r <= a_slot_r;
    end
  end

  assign out_valid = !b_empty;
  assign out_ent   = b_slot_r[b_ptr_r];
  assign out_last  = ({1'b0, b_ptr_r} == b_cnt_r - 3'd1);

endmodule

`default_nettype wire

// File: rtl/zscii_text_word_decoder_top.sv
// ZSCII text word decoder: each transfer on in_ carries one 16-bit packed text word; three
// combinational decode lanes split it into its codes (high to low) and the merge stage
// queues the zero to four results (characters, abbreviation requests, an end item when
// bit 15 is set), which leave on out_ one per cycle while out_tready is high, with tlast
// on the last of each word. A word is accepted in the cycle it arrives while the holding
// stage is free, so the sustained rate is set by the single output channel; words
// producing no result leave the holding stage free. Decode of a word sees state left by
// the previous accepted word only, so no bubbles are inserted between words.
// abbrev_enable lies at byte address 0 of the cfg_ port and resets to 1.
`timescale 1ns / 1ps
`default_nettype none

`include "zscii_text_word_decoder_top_assert.svh"

module zscii_text_word_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] text_word
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] char_code, [14:8] abbrev_index, [15] zero
  output logic [1:0]       out_tuser,  // [1:0] item_kind
  output logic             out_tlast,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic                abbrev_en_r;
  zsd_pkg::dec_state_t state_r, state_nxt;
  zsd_pkg::dec_state_t lane_st [zsd_pkg::NUM_LANES + 1];
  zsd_pkg::dec_res_t   lane_res [zsd_pkg::NUM_RES];
  zsd_pkg::out_ent_t   out_ent;
  logic                accept;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {31'd0, abbrev_en_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abbrev_en_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == 1'b0) begin
      abbrev_en_r <= cfg_pwdata[0];
    end
  end

  assign accept = in_tvalid && in_tready;

  // Decode lanes, chained through the running state
  assign lane_st[0] = state_r;

  for (genvar g = 0; g < zsd_pkg::NUM_LANES; g++) begin : g_lane
    zsd_lane u_lane (
      .zcode     (1'b1),
      .code      (in_tdata[14 - 5*g -: 5]),
      .abbrev_en (abbrev_en_r),
      .st_in     (lane_st[g]),
      .st_out    (lane_st[g+1]),
      .res       (lane_res[g])
    );
  end

  // End of string result
  assign lane_res[zsd_pkg::NUM_LANES] = '{vld: in_tdata[15], kind: zsd_pkg::KIND_END,
                                          ch: 8'd0, idx: 7'd0};

  assign state_nxt = in_tdata[15] ? '0 : lane_st[zsd_pkg::NUM_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // Merge and output
  zsd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (lane_res),
    .accept    (accept),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_ent   (out_ent),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, out_ent.idx, out_ent.ch};
  assign out_tuser = out_ent.kind;

  // Checks
  `ZSD_ASSERT_IMPL(a_end_is_last, out_tvalid && out_tuser == zsd_pkg::KIND_END, out_tlast, "end item not last of word")
  `ZSD_ASSERT_NEXT(a_end_clears, accept && in_tdata[15], state_r == '0, "state not cleared at end of string")
  `ZSD_ASSERT_IMPL(a_abbrev_fields, out_tvalid && out_tuser == zsd_pkg::KIND_ABBREV, out_tdata[7:0] == 8'd0 && out_tdata[14:13] != 2'b11, "bad abbreviation fields")

endmodule

`default_nettype wire

// File: sim/zscii_text_word_decoder_top_tb.sv
`timescale 1ns / 1ps

module zscii_text_word_decoder_top_tb;

  localparam int         CLK_HALF     = 5;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         DRAIN_CYCLES = 12;
  localparam int         LONG_HOLD    = 300;
  localparam logic [2:0] REG_ABBREV_EN = 3'd0;
  // abbreviation bank codes below the top one
  localparam logic [4:0] CODE_ABBR_LO  = 5'd1;
  localparam logic [4:0] CODE_ABBR_MID = 5'd2;

  // one decoded item as seen on the result stream
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [6:0] idx;
    logic       last;
  } text_result_t;

  // tracks decoder state and the queue of decoded items still due
  class text_decode_board;
    logic [1:0]   shift;
    logic [1:0]   pmode;
    logic [4:0]   pbits;
    bit           abbrev_en;
    string        punct_map;
    text_result_t expected_q[$];
    int           errors;

    function new();
      // escape slot reads as a query mark
      punct_map = "?\n0123456789.,!?_#'\"/\\-:()";
      abbrev_en = 1'b1;
      shift     = zsd_pkg::SHIFT_LOWER;
      pmode     = zsd_pkg::PEND_NONE;
      pbits     = '0;
      errors    = 0;
    endfunction

    function void push(logic [1:0] kind, logic [7:0] ch, logic [6:0] idx);
      text_result_t r;
      r.kind = kind;
      r.ch   = ch;
      r.idx  = idx;
      r.last = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void decode_code(logic [4:0] z);
      logic [1:0] bank;
      logic [7:0] ch;
      bank = pbits[1:0] - 2'd1;
      case (pmode)
        zsd_pkg::PEND_ABBR: begin
          push(zsd_pkg::KIND_ABBREV, 8'h00, {bank, z});
          pmode = zsd_pkg::PEND_NONE;
          pbits = '0;
        end
        zsd_pkg::PEND_LIT_HI: begin
          pbits = z;
          pmode = zsd_pkg::PEND_LIT_LO;
        end
        zsd_pkg::PEND_LIT_LO: begin
          // literal keeps only its low byte
          push(zsd_pkg::KIND_CHAR, {pbits[2:0], z}, 7'd0);
          pmode = zsd_pkg::PEND_NONE;
          pbits = '0;
        end
        default: begin
          if (z == zsd_pkg::CODE_SPACE) begin
            push(zsd_pkg::KIND_CHAR, zsd_pkg::CH_SPACE, 7'd0);
            shift = zsd_pkg::SHIFT_LOWER;
          end else if (z <= zsd_pkg::CODE_ABBR_HI) begin
            if (abbrev_en) begin
              pmode = zsd_pkg::PEND_ABBR;
              pbits = z;
            end
            shift = zsd_pkg::SHIFT_LOWER;
          end else if (z == zsd_pkg::CODE_SH_UP) begin
            shift = zsd_pkg::SHIFT_UPPER;
          end else if (z == zsd_pkg::CODE_SH_PUN) begin
            shift = zsd_pkg::SHIFT_PUNCT;
          end else if (shift == zsd_pkg::SHIFT_PUNCT && z == zsd_pkg::CODE_LITERAL) begin
            pmode = zsd_pkg::PEND_LIT_HI;
            pbits = '0;
            shift = zsd_pkg::SHIFT_LOWER;
          end else begin
            case (shift)
              zsd_pkg::SHIFT_LOWER: ch = zsd_pkg::CH_LOW_A + 8'(z - zsd_pkg::CODE_BASE);
              zsd_pkg::SHIFT_UPPER: ch = zsd_pkg::CH_UP_A + 8'(z - zsd_pkg::CODE_BASE);
              default:              ch = punct_map[int'(z - zsd_pkg::CODE_BASE)];
            endcase
            push(zsd_pkg::KIND_CHAR, ch, 7'd0);
            shift = zsd_pkg::SHIFT_LOWER;
          end
        end
      endcase
    endfunction

    // predict everything one accepted text word produces
    function void note_word(logic [15:0] w);
      int           n_prior;
      text_result_t r;
      n_prior = expected_q.size();
      decode_code(w[14:10]);
      decode_code(w[9:5]);
      decode_code(w[4:0]);
      if (w[15]) begin
        shift = zsd_pkg::SHIFT_LOWER;
        pmode = zsd_pkg::PEND_NONE;
        pbits = '0;
        push(zsd_pkg::KIND_END, 8'h00, 7'd0);
      end
      if (expected_q.size() > n_prior) begin
        r      = expected_q.pop_back();
        r.last = 1'b1;
        expected_q.push_back(r);
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [15:0] data, logic last);
      text_result_t got;
      text_result_t want;
      got.kind = kind;
      got.ch   = data[7:0];
      got.idx  = data[14:8];
      got.last = last;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: kind %0d char %h index %0d last %0b",
                 $time, got.kind, got.ch, got.idx, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (data[15] !== 1'b0 || got !== want) begin
        errors++;
        $display("%0t: mismatch: expected kind %0d char %h index %0d last %0b pad 0",
                 $time, want.kind, want.ch, want.idx, want.last);
        $display("%0t:           actual   kind %0d char %h index %0d last %0b pad %b",
                 $time, got.kind, got.ch, got.idx, got.last, data[15]);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;     // [15:0] text_word
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;    // [7:0] char_code, [14:8] abbrev_index, [15] zero
  logic [1:0]  out_tuser;    // [1:0] item_kind
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  text_decode_board board;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold      = 0;
  int words_taken  = 0;
  int cycle_count  = 0;

  zscii_text_word_decoder_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #CLK_HALF clk = ~clk;

  // sample both streams at the rising edge
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        board.check_result(out_tuser, out_tdata, out_tlast);
      end
      if (in_tvalid && in_tready) begin
        board.note_word(in_tdata);
        words_taken++;
      end
    end
  end

  // result side: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold--;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [15:0] pack_codes(bit fin, logic [4:0] a, logic [4:0] b,
                                             logic [4:0] c);
    return {fin, a, b, c};
  endfunction

  // biased towards shifts, literals and abbreviations
  function automatic logic [4:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 14) return zsd_pkg::CODE_SPACE;
    if (r < 28) return 5'($urandom_range(3, 1));
    if (r < 40) return zsd_pkg::CODE_SH_UP;
    if (r < 55) return zsd_pkg::CODE_SH_PUN;
    if (r < 65) return zsd_pkg::CODE_LITERAL;
    return 5'($urandom_range(31));
  endfunction

  function automatic logic [15:0] random_word();
    if ($urandom_range(3) == 0) return 16'($urandom());
    return {($urandom_range(7) == 0), pick_code(), pick_code(), pick_code()};
  endfunction

  // offer one word, called at a falling edge; returns at the falling edge after the transfer
  task automatic send_word(input logic [15:0] w);
    int taken0;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    taken0 = words_taken;
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(negedge clk); while (words_taken == taken0);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_word(random_word());
  endtask

  // let every due item arrive, then allow for words still in flight
  task automatic settle();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_abbrev_en(input logic v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_ABBREV_EN;
    cfg_pwdata  <= {31'd0, v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    board.abbrev_en = v;
  endtask

  initial begin
    board       = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words, abbreviations enabled from reset
    send_word(16'h0000);
    send_word(pack_codes(1'b0, zsd_pkg::CODE_SH_UP, zsd_pkg::CODE_BASE, zsd_pkg::CODE_SH_PUN));
    send_word(pack_codes(1'b0, 5'd7, zsd_pkg::CODE_SH_PUN, zsd_pkg::CODE_LITERAL));
    send_word(pack_codes(1'b0, 5'd31, 5'd31, zsd_pkg::CODE_SPACE));       // literal wraps to ff
    send_word(pack_codes(1'b0, zsd_pkg::CODE_SH_PUN, zsd_pkg::CODE_LITERAL, 5'd3));
    send_word(pack_codes(1'b0, CODE_ABBR_LO, zsd_pkg::CODE_SH_UP, 5'd31)); // literal spans words
    send_word(pack_codes(1'b0, CODE_ABBR_LO, zsd_pkg::CODE_SPACE, CODE_ABBR_MID));
    send_word(pack_codes(1'b0, 5'd31, zsd_pkg::CODE_ABBR_HI, 5'd31));
    send_word(pack_codes(1'b0, zsd_pkg::CODE_SH_UP, zsd_pkg::CODE_SH_PUN, 5'd8)); // later shift wins
    send_word(pack_codes(1'b0, zsd_pkg::CODE_SH_PUN, zsd_pkg::CODE_SH_UP, zsd_pkg::CODE_BASE));
    send_word(pack_codes(1'b0, zsd_pkg::CODE_SH_UP, zsd_pkg::CODE_SPACE, zsd_pkg::CODE_BASE));
    send_word(pack_codes(1'b0, zsd_pkg::CODE_SH_PUN, CODE_ABBR_LO, 5'd10));
    send_word(pack_codes(1'b0, zsd_pkg::CODE_SH_PUN, 5'd31, zsd_pkg::CODE_SH_PUN));
    send_word(pack_codes(1'b0, 5'd19, zsd_pkg::CODE_SH_UP, zsd_pkg::CODE_SH_UP));
    // end of string dropping pending work
    send_word(pack_codes(1'b1, zsd_pkg::CODE_SPACE, zsd_pkg::CODE_SPACE, CODE_ABBR_MID));
    send_word(pack_codes(1'b1, zsd_pkg::CODE_SH_PUN, zsd_pkg::CODE_LITERAL, 5'd12));
    send_word(pack_codes(1'b1, zsd_pkg::CODE_SPACE, zsd_pkg::CODE_SH_PUN,
                         zsd_pkg::CODE_LITERAL));
    send_word(pack_codes(1'b1, zsd_pkg::CODE_SPACE, zsd_pkg::CODE_SPACE, zsd_pkg::CODE_SH_UP));
    send_word(pack_codes(1'b0, zsd_pkg::CODE_BASE, zsd_pkg::CODE_SH_UP, zsd_pkg::CODE_SH_PUN));
    // words giving nothing or only an end item, then words of all-ones codes
    send_word(pack_codes(1'b0, zsd_pkg::CODE_SH_UP, zsd_pkg::CODE_SH_PUN, zsd_pkg::CODE_SH_UP));
    send_word(pack_codes(1'b1, zsd_pkg::CODE_SH_UP, zsd_pkg::CODE_SH_UP, zsd_pkg::CODE_SH_UP));
    send_word(16'hffff);
    send_word(16'h7fff);
    // leave an abbreviation open across the register change
    send_word(pack_codes(1'b0, zsd_pkg::CODE_SPACE, zsd_pkg::CODE_SPACE, zsd_pkg::CODE_ABBR_HI));
    settle();
    write_abbrev_en(1'b0);
    send_word(pack_codes(1'b0, 5'd7, CODE_ABBR_LO, 5'd8));
    send_word(pack_codes(1'b0, zsd_pkg::CODE_SH_PUN, CODE_ABBR_MID, zsd_pkg::CODE_LITERAL));
    send_word(pack_codes(1'b0, zsd_pkg::CODE_SH_UP, zsd_pkg::CODE_ABBR_HI, zsd_pkg::CODE_BASE));

    // sender idles, abbreviations off
    tx_idle_pct = 63;
    send_random(55);
    settle();

    // receiver stalls, with one long hold-off to back the block up
    write_abbrev_en(1'b1);
    tx_idle_pct  = 0;
    rx_stall_pct = 63;
    rx_hold      = LONG_HOLD;
    send_random(70);
    settle();

    // both sides idle now and then
    write_abbrev_en(1'b0);
    tx_idle_pct  = 18;
    rx_stall_pct = 18;
    send_random(55);
    settle();

    // full rate
    write_abbrev_en(1'b1);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_random(53);
    settle();

    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
